// ----- rtl/ambc_pkg.sv -----
// Shared codes, types and base helpers for the banded mismatch-count aligner.
`timescale 1ns / 1ps
package ambc_pkg;

	// Command codes carried in the input tuser
	localparam logic [1:0] CMD_REF  = 2'd0;
	localparam logic [1:0] CMD_READ = 2'd1;
	localparam logic [1:0] CMD_RUN  = 2'd2;

	// Result status codes
	localparam logic [1:0] STS_ALIGNED = 2'd0;
	localparam logic [1:0] STS_GAP     = 2'd1;
	localparam logic [1:0] STS_LOW     = 2'd2;
	localparam logic [1:0] STS_OVF     = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] CFG_MATCH    = 3'd0;
	localparam logic [2:0] CFG_MISMATCH = 3'd1;
	localparam logic [2:0] CFG_GAP      = 3'd2;
	localparam logic [2:0] CFG_MIN      = 3'd3;
	localparam logic [2:0] CFG_BAND     = 3'd4;

	// Traceback move codes
	localparam logic [1:0] MV_DIAG = 2'd0;
	localparam logic [1:0] MV_DEL  = 2'd1;
	localparam logic [1:0] MV_INS  = 2'd2;

	// Base characters
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UC = 8'h43;
	localparam logic [7:0] CH_UG = 8'h47;
	localparam logic [7:0] CH_UT = 8'h54;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LC = 8'h63;
	localparam logic [7:0] CH_LG = 8'h67;
	localparam logic [7:0] CH_LT = 8'h74;
	localparam logic [7:0] CH_N  = 8'h4E;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_FILL,
		ST_BEST,
		ST_TB_REQ,
		ST_TB_EVAL,
		ST_OUT
	} state_t;

	// Complement a base; anything that is not A/C/G/T becomes N
	function automatic logic [7:0] comp_base(input logic [7:0] b);
		logic [7:0] r;
		case (b) inside
			CH_UA, CH_LA: r = CH_UT;
			CH_UC, CH_LC: r = CH_UG;
			CH_UG, CH_LG: r = CH_UC;
			CH_UT, CH_LT: r = CH_UA;
			default: r = CH_N;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/ambc_base_buf.sv -----
// Base buffer: loads raw bytes in order and reads them forward or reverse-complemented.
`timescale 1ns / 1ps
module ambc_base_buf import ambc_pkg::*; #(
	parameter int MAX_BASES = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [7:0]                         wr_data,
	input  logic                               clr,
	input  logic                               rev,
	input  logic [$clog2(MAX_BASES)-1:0]       rd_k,
	output logic [$clog2(MAX_BASES+1)-1:0]     count,
	output logic                               full,
	output logic [7:0]                         rd_base
);
	localparam int AW = $clog2(MAX_BASES);
	localparam int CW = $clog2(MAX_BASES + 1);

	logic [7:0]    mem [MAX_BASES];
	logic [7:0]    rd_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] addr;

	assign count = count_q;
	assign full  = (count_q == CW'(MAX_BASES));

	// Advance the fill count on each kept load, drop it after a run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clr) begin
			count_q <= '0;
		end else if (wr_en && !full) begin
			count_q <= count_q + CW'(1);
		end
	end

	// Map a work index to its stored position
	always_comb begin
		if (rev) begin
			addr = AW'(count_q - CW'(1) - CW'(rd_k));
		end else begin
			addr = rd_k;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && !full) begin
			mem[count_q[AW-1:0]] <= wr_data;
		end
		rd_q <= mem[addr];
	end

	assign rd_base = rev ? comp_base(rd_q) : rd_q;

endmodule

// ----- rtl/ambc_cell.sv -----
// One band cell: holds the score of one band diagonal and its column of traceback moves.
`timescale 1ns / 1ps
module ambc_cell import ambc_pkg::*; #(
	parameter int CIDX       = 0,
	parameter int MAX_BAND   = 32,
	parameter int MAX_BASES  = 256,
	parameter int SCORE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 init,
	input  logic [$clog2(MAX_BAND+1)-1:0]        band,
	input  logic [$clog2(MAX_BASES+1)-1:0]       ql,
	input  logic [$clog2(MAX_BASES+1)-1:0]       rl,
	input  logic signed [5:0]                    match_sc,
	input  logic signed [5:0]                    mism_sc,
	input  logic signed [5:0]                    gap_sc,
	input  logic                                 ref_in_v,
	input  logic [$clog2(MAX_BASES+1)-1:0]       ref_in_i,
	input  logic [7:0]                           ref_in_b,
	input  logic [7:0]                           rd_in_b,
	input  logic signed [SCORE_BITS-1:0]         s_left,
	input  logic signed [SCORE_BITS-1:0]         s_right,
	input  logic [$clog2(MAX_BASES)-1:0]         tb_addr,
	output logic                                 ref_v_q,
	output logic [$clog2(MAX_BASES+1)-1:0]       ref_i_q,
	output logic [7:0]                           ref_b_q,
	output logic [7:0]                           rd_b_q,
	output logic signed [SCORE_BITS-1:0]         s_q,
	output logic [1:0]                           tb_op_q,
	output logic                                 col_hit_q,
	output logic                                 row_hit_q,
	output logic signed [SCORE_BITS-1:0]         ev_v_q,
	output logic [$clog2(MAX_BASES+1)-1:0]       ev_i_q,
	output logic [$clog2(MAX_BASES+1)-1:0]       ev_j_q
);
	localparam int SB    = SCORE_BITS;
	localparam int AW    = $clog2(MAX_BASES);
	localparam int CW    = $clog2(MAX_BASES + 1);
	localparam int BW    = $clog2(MAX_BAND + 1);
	localparam int JW    = CW + 2;
	localparam int DOFF  = CIDX - MAX_BAND;
	localparam int ADOFF = (DOFF < 0) ? -DOFF : DOFF;
	localparam logic signed [SB-1:0] FLOOR = {1'b1, {(SB-1){1'b0}}};
	localparam logic signed [SB-1:0] TOPS  = {1'b0, {(SB-1){1'b1}}};

	logic [1:0] tr_mem [MAX_BASES];

	logic                 active;
	logic signed [JW-1:0] j;
	logic signed [JW-1:0] qls;
	logic                 j_zero;
	logic                 j_out;
	logic                 eq;
	logic signed [SB-1:0] diag_v;
	logic signed [SB-1:0] del_v;
	logic signed [SB-1:0] ins_v;
	logic signed [SB-1:0] best_v;
	logic [1:0]           op;
	logic signed [SB-1:0] new_s;
	logic signed [SB-1:0] init_s;
	logic                 wr_move;

	// Add a score step and clamp to the signed score range
	function automatic logic signed [SB-1:0] add_sat(input logic signed [SB-1:0] a,
			input logic signed [5:0] sc);
		logic signed [SB:0] x;
		x = $signed({a[SB-1], a}) + (SB+1)'(sc);
		if (x[SB] != x[SB-1]) begin
			return x[SB] ? FLOOR : TOPS;
		end
		return x[SB-1:0];
	endfunction

	assign active = (BW'(ADOFF) <= band);
	assign j      = $signed({2'b00, ref_i_q}) + JW'(DOFF);
	assign qls    = $signed({2'b00, ql});
	assign j_zero = (j == '0);
	assign j_out  = (j < 0) || (j > qls);

	// Pick the best of diagonal, deletion and insertion; ties keep the earlier one
	always_comb begin
		eq     = (ref_b_q == rd_b_q);
		diag_v = add_sat(s_q, eq ? match_sc : mism_sc);
		del_v  = add_sat(s_right, gap_sc);
		ins_v  = add_sat(s_left, gap_sc);
		best_v = diag_v;
		op     = MV_DIAG;
		if (del_v > best_v) begin
			best_v = del_v;
			op     = MV_DEL;
		end
		if (ins_v > best_v) begin
			best_v = ins_v;
			op     = MV_INS;
		end
		if (!active) begin
			new_s = FLOOR;
		end else if (j_zero) begin
			new_s = '0;
		end else if (j_out) begin
			new_s = FLOOR;
		end else begin
			new_s = best_v;
		end
		wr_move = ref_v_q && active && !j_zero && !j_out;
		if (active && (DOFF >= 0) && (JW'(DOFF) <= qls)) begin
			init_s = '0;
		end else begin
			init_s = FLOOR;
		end
	end

	// Pass reference tokens right and read bases left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_v_q   <= 1'b0;
			col_hit_q <= 1'b0;
			row_hit_q <= 1'b0;
		end else begin
			ref_v_q   <= ref_in_v;
			col_hit_q <= ref_v_q && active && (j == qls);
			row_hit_q <= ref_v_q && active && (ref_i_q == rl) && !j_out;
		end
	end

	// Hold the score of this diagonal, updated once per row
	always_ff @(posedge clk) begin
		ref_i_q <= ref_in_i;
		ref_b_q <= ref_in_b;
		rd_b_q  <= rd_in_b;
		ev_v_q  <= new_s;
		ev_i_q  <= ref_i_q;
		ev_j_q  <= j[CW-1:0];
		if (init) begin
			s_q <= init_s;
		end else if (ref_v_q) begin
			s_q <= new_s;
		end
	end

	// Store moves by row, read one back for traceback
	always_ff @(posedge clk) begin
		if (wr_move) begin
			tr_mem[AW'(ref_i_q - CW'(1))] <= op;
		end
		tb_op_q <= tr_mem[tb_addr];
	end

endmodule

// ----- rtl/banded_align_mismatch_count_core.sv -----
// Top level of the banded aligner: base buffers, band cell chain, best search and traceback.
`timescale 1ns / 1ps
// Usage:
//   s_* carries commands: tuser holds cmd; tdata holds base and the two reverse flags.
//   Load commands store one base per cycle while idle; a load into a full buffer is dropped
//   and flags overflow. A run aligns both buffers and gives one result on m_*
//   (tdata mismatch count, tuser status), then empties both buffers.
//   cfg_* writes the scoring registers; they must be written only while idle.
// Run:
//   A run fills the band with a chain of 2*MAX_BAND+1
//   cells, then picks the best cell, then traces back; each traceback step is
//   a trace and base memory read followed by an update, at most as many
//   steps as both lengths together. A length-gap reject skips the fill and
//   the traceback.
// Reset clears counts, overflow and the handshake state; the registers return
// to their defaults. A result held by a stalled receiver stays in the output
// register; loads are still taken, and a further run finishes its work and
// waits there until the slot is free.
module banded_align_mismatch_count_core import ambc_pkg::*; #(
	parameter int MAX_BASES  = 256,
	parameter int MAX_BAND   = 32,
	parameter int SCORE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // base[7:0], ref_reverse[8], read_reverse[9], zero
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // mismatch_count[8:0], zero
	output logic [1:0]  m_tuser,   // status[1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [13:0] cfg_data
);
	localparam int SB = SCORE_BITS;
	localparam int NC = 2 * MAX_BAND + 1;
	localparam int AW = $clog2(MAX_BASES);
	localparam int CW = $clog2(MAX_BASES + 1);
	localparam int BW = $clog2(MAX_BAND + 1);
	localparam int BEW = (BW > 6) ? BW : 6;
	localparam int NW = $clog2(NC);
	localparam int TW = $clog2(2 * MAX_BASES + 2 * MAX_BAND + 6);
	localparam int MW = ((SB > 14) ? SB : 14) + 1;
	localparam logic signed [SB-1:0] FLOOR = {1'b1, {(SB-1){1'b0}}};

	state_t state_q, state_d;

	logic signed [5:0]  match_q, mism_q, gap_q;
	logic signed [13:0] min_q;
	logic [5:0]         bw_q;
	logic [BEW-1:0]     band_ext;
	logic [BW-1:0]      band;

	logic          ref_rev_q, rd_rev_q, ovf_q;
	logic [CW-1:0] rl, ql;
	logic          ref_full, rd_full;
	logic [7:0]    ref_base, rd_base;
	logic [AW-1:0] ref_k, rd_k;
	logic          buf_clr;
	logic          in_xfer, load_ref, load_rd, run_cmd;

	logic [TW-1:0]   t_q;
	logic [TW-2:0]   half;
	logic [TW-1:0]   t_last;
	logic            fr_v_s1;
	logic [CW-1:0]   fr_i_s1;

	logic                 ref_v_w  [NC];
	logic [CW-1:0]        ref_i_w  [NC];
	logic [7:0]           ref_b_w  [NC];
	logic [7:0]           rd_b_w   [NC];
	logic signed [SB-1:0] s_w      [NC];
	logic [1:0]           tb_op_w  [NC];
	logic                 col_hit_w[NC];
	logic                 row_hit_w[NC];
	logic signed [SB-1:0] ev_v_w   [NC];
	logic [CW-1:0]        ev_i_w   [NC];
	logic [CW-1:0]        ev_j_w   [NC];

	logic                 col_any, row_any;
	logic signed [SB-1:0] col_v, row_v;
	logic [CW-1:0]        col_i, row_j;
	logic signed [SB-1:0] colbest_q, rowbest_q;
	logic [CW-1:0]        coli_q, rowj_q;

	logic                 use_col;
	logic signed [SB-1:0] best;
	logic                 low_score;
	logic signed [CW:0]   gap_diff;
	logic [CW:0]          gap_abs;
	logic                 gap_bad;

	logic [CW-1:0]        tb_i_q, tb_j_q;
	logic signed [CW:0]   tb_diff;
	logic [CW:0]          tb_abs;
	logic signed [CW+1:0] tb_sum;
	logic [AW-1:0]        tb_addr;
	logic [NW-1:0]        tb_idx_s1;
	logic                 tb_inb_s1;
	logic [1:0]           tb_op;
	logic                 tb_mis;
	logic [8:0]           mism_cnt_q;
	logic [1:0]           status_q;
	logic                 out_free;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign load_ref  = in_xfer && (s_tuser == CMD_REF);
	assign load_rd   = in_xfer && (s_tuser == CMD_READ);
	assign run_cmd   = in_xfer && (s_tuser == CMD_RUN);
	assign out_free  = !m_tvalid || m_tready;
	assign buf_clr   = (state_q == ST_OUT) && out_free;

	// Clamp the band to MAX_BAND
	assign band_ext = BEW'(bw_q);
	assign band     = (band_ext > BEW'(MAX_BAND)) ? BW'(MAX_BAND) : BW'(band_ext);

	// Hold the scoring registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 6'sd1;
			mism_q  <= -6'sd1;
			gap_q   <= -6'sd1;
			min_q   <= '0;
			bw_q    <= 6'd16;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MATCH:    match_q <= cfg_data[5:0];
				CFG_MISMATCH: mism_q  <= cfg_data[5:0];
				CFG_GAP:      gap_q   <= cfg_data[5:0];
				CFG_MIN:      min_q   <= cfg_data;
				CFG_BAND:     bw_q    <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// Feed counter: token for row or column t/2 when t is even
	assign half   = t_q[TW-1:1];
	assign t_last = TW'({rl, 1'b0}) + TW'(2 * MAX_BAND + 4);
	assign ref_k  = (state_q == ST_TB_REQ) ? AW'(tb_i_q - CW'(1)) : AW'(half - (TW-1)'(1));
	assign rd_k   = (state_q == ST_TB_REQ) ? AW'(tb_j_q - CW'(1)) : AW'(half - (TW-1)'(1));
	assign tb_addr = AW'(tb_i_q - CW'(1));

	ambc_base_buf #(.MAX_BASES(MAX_BASES)) u_ref_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (load_ref),
		.wr_data (s_tdata[7:0]),
		.clr     (buf_clr),
		.rev     (ref_rev_q),
		.rd_k    (ref_k),
		.count   (rl),
		.full    (ref_full),
		.rd_base (ref_base)
	);

	ambc_base_buf #(.MAX_BASES(MAX_BASES)) u_rd_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (load_rd),
		.wr_data (s_tdata[7:0]),
		.clr     (buf_clr),
		.rev     (rd_rev_q),
		.rd_k    (rd_k),
		.count   (ql),
		.full    (rd_full),
		.rd_base (rd_base)
	);

	// Build the band chain
	for (genvar c = 0; c < NC; c++) begin : g_cell
		logic                 in_v;
		logic [CW-1:0]        in_i;
		logic [7:0]           in_b;
		logic [7:0]           in_rb;
		logic signed [SB-1:0] sl, sr;
		if (c == 0) begin : g_first
			assign in_v = fr_v_s1;
			assign in_i = fr_i_s1;
			assign in_b = ref_base;
			assign sl   = FLOOR;
		end else begin : g_mid
			assign in_v = ref_v_w[c-1];
			assign in_i = ref_i_w[c-1];
			assign in_b = ref_b_w[c-1];
			assign sl   = s_w[c-1];
		end
		if (c == NC - 1) begin : g_last
			assign in_rb = rd_base;
			assign sr    = FLOOR;
		end else begin : g_inner
			assign in_rb = rd_b_w[c+1];
			assign sr    = s_w[c+1];
		end
		ambc_cell #(
			.CIDX       (c),
			.MAX_BAND   (MAX_BAND),
			.MAX_BASES  (MAX_BASES),
			.SCORE_BITS (SCORE_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.init      (state_q == ST_INIT),
			.band      (band),
			.ql        (ql),
			.rl        (rl),
			.match_sc  (match_q),
			.mism_sc   (mism_q),
			.gap_sc    (gap_q),
			.ref_in_v  (in_v),
			.ref_in_i  (in_i),
			.ref_in_b  (in_b),
			.rd_in_b   (in_rb),
			.s_left    (sl),
			.s_right   (sr),
			.tb_addr   (tb_addr),
			.ref_v_q   (ref_v_w[c]),
			.ref_i_q   (ref_i_w[c]),
			.ref_b_q   (ref_b_w[c]),
			.rd_b_q    (rd_b_w[c]),
			.s_q       (s_w[c]),
			.tb_op_q   (tb_op_w[c]),
			.col_hit_q (col_hit_w[c]),
			.row_hit_q (row_hit_w[c]),
			.ev_v_q    (ev_v_w[c]),
			.ev_i_q    (ev_i_w[c]),
			.ev_j_q    (ev_j_w[c])
		);
	end

	// Merge the one-hot last-row and last-column reports
	always_comb begin
		col_any = 1'b0;
		row_any = 1'b0;
		col_v   = '0;
		row_v   = '0;
		col_i   = '0;
		row_j   = '0;
		for (int c = 0; c < NC; c++) begin
			col_any = col_any | col_hit_w[c];
			row_any = row_any | row_hit_w[c];
			col_v   = col_v | (col_hit_w[c] ? ev_v_w[c] : '0);
			col_i   = col_i | (col_hit_w[c] ? ev_i_w[c] : '0);
			row_v   = row_v | (row_hit_w[c] ? ev_v_w[c] : '0);
			row_j   = row_j | (row_hit_w[c] ? ev_j_w[c] : '0);
		end
	end

	// Length check, best pick and traceback arithmetic
	always_comb begin
		gap_diff  = $signed({1'b0, rl}) - $signed({1'b0, ql});
		gap_abs   = (gap_diff < 0) ? (CW+1)'(0) - gap_diff : gap_diff;
		gap_bad   = (gap_abs > (CW+1)'(band));
		use_col   = (colbest_q > rowbest_q);
		best      = use_col ? colbest_q : rowbest_q;
		low_score = ($signed(MW'(best)) < $signed(MW'(min_q)));
		tb_diff   = $signed({1'b0, tb_j_q}) - $signed({1'b0, tb_i_q});
		tb_abs    = (tb_diff < 0) ? (CW+1)'(0) - tb_diff : tb_diff;
		tb_sum    = (CW+2)'(tb_diff) + (CW+2)'(MAX_BAND);
		tb_op     = tb_inb_s1 ? tb_op_w[tb_idx_s1] : MV_DIAG;
		tb_mis    = (ref_base != rd_base);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (run_cmd) state_d = gap_bad ? ST_OUT : ST_INIT;
			ST_INIT:    state_d = ST_FILL;
			ST_FILL:    if (t_q == t_last) state_d = ST_BEST;
			ST_BEST:    state_d = low_score ? ST_OUT : ST_TB_REQ;
			ST_TB_REQ:  state_d = (tb_i_q == '0 || tb_j_q == '0) ? ST_OUT : ST_TB_EVAL;
			ST_TB_EVAL: state_d = ST_TB_REQ;
			ST_OUT:     if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: overflow, feed token, output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q    <= 1'b0;
			fr_v_s1  <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (buf_clr) begin
				ovf_q <= 1'b0;
			end else if ((load_ref && ref_full) || (load_rd && rd_full)) begin
				ovf_q <= 1'b1;
			end
			fr_v_s1 <= (state_q == ST_FILL) && !t_q[0] && (half != '0) && (half <= rl);
			if (buf_clr) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// Datapath registers of the run
	always_ff @(posedge clk) begin
		fr_i_s1 <= CW'(half);
		if (run_cmd) begin
			ref_rev_q  <= s_tdata[8];
			rd_rev_q   <= s_tdata[9];
			status_q   <= STS_GAP;
			mism_cnt_q <= '0;
		end
		if (state_q == ST_INIT) begin
			t_q       <= '0;
			colbest_q <= (ql <= CW'(band)) ? '0 : FLOOR;
			coli_q    <= '0;
			rowbest_q <= (rl == '0) ? '0 : FLOOR;
			rowj_q    <= (rl == '0) ? '0 : ql;
		end else begin
			t_q <= t_q + TW'(1);
			if (col_any && (col_v > colbest_q)) begin
				colbest_q <= col_v;
				coli_q    <= col_i;
			end
			if (row_any && (row_v > rowbest_q)) begin
				rowbest_q <= row_v;
				rowj_q    <= row_j;
			end
		end
		if (state_q == ST_BEST) begin
			status_q <= STS_LOW;
			tb_i_q   <= use_col ? coli_q : rl;
			tb_j_q   <= use_col ? ql : rowj_q;
		end
		if (state_q == ST_TB_REQ) begin
			status_q  <= ovf_q ? STS_OVF : STS_ALIGNED;
			tb_inb_s1 <= (tb_abs <= (CW+1)'(band));
			tb_idx_s1 <= tb_sum[NW-1:0];
		end
		if (state_q == ST_TB_EVAL) begin
			case (tb_op)
				MV_DIAG: begin
					if (tb_mis && (mism_cnt_q != 9'h1FF)) begin
						mism_cnt_q <= mism_cnt_q + 9'd1;
					end
					tb_i_q <= tb_i_q - CW'(1);
					tb_j_q <= tb_j_q - CW'(1);
				end
				MV_DEL: tb_i_q <= tb_i_q - CW'(1);
				default: tb_j_q <= tb_j_q - CW'(1);
			endcase
		end
		if (buf_clr) begin
			m_tuser <= status_q;
			m_tdata <= (status_q == STS_GAP || status_q == STS_LOW) ? 16'd0
				: {7'd0, mism_cnt_q};
		end
	end

endmodule
